FILE: hw/rtl/apr_pkg.sv
package apr_pkg;

   // Operation codes carried by req_opcode.
   localparam logic [1:0] OP_REFERENCE = 2'd0;
   localparam logic [1:0] OP_MAP       = 2'd1;
   localparam logic [1:0] OP_VICTIM    = 2'd2;

   // Frame count register value after reset.
   localparam logic [7:0] FRAMES_RESET = 8'd128;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_SCAN,
      ST_DRAIN
   } state_type;

endpackage

FILE: hw/rtl/aging_page_replacement.sv
// Aging page replacement engine. A reference or map beat is taken while busy is low and gives no
// result. A victim beat keeps busy high through the modulo, scan and drain states, where n is the
// effective frame count (frames_in_use clipped to 1..NUM_FRAMES) and FW is clog2(NUM_FRAMES): the
// modulo state reduces the scan head modulo n one bit at a time over its FW bits, then the scan
// state streams every frame in use through a single read port of the age and referenced-bit
// memories, each frame being aged, written back and compared as it comes out, and the drain state
// takes the last read. The result appears on rsp_victim_frame and rsp_victim_age for exactly one
// cycle with rsp_strobe high, in the cycle busy falls; it is not held, so the receiver must take it
// then. After reset, busy stays high while both memories are cleared one entry per cycle. The
// configuration channel is always ready; write it only while busy is low and no result is due.
module aging_page_replacement
   import apr_pkg::*;
#(
   parameter int NUM_FRAMES = 128,
   parameter int AGE_BITS   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [6:0]  req_frame_index,
   output logic        rsp_strobe,
   output logic [6:0]  rsp_victim_frame,
   output logic [31:0] rsp_victim_age,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_frames_in_use
);

   // Frame address width, frame count width, remainder width and step count width for the modulo unit.
   localparam int FW = $clog2(NUM_FRAMES);
   localparam int CW = $clog2(NUM_FRAMES + 1);
   localparam int RW = CW + 1;
   localparam int SW = $clog2(FW + 1);

   localparam logic [FW-1:0] CLR_LAST  = FW'(NUM_FRAMES - 1);
   localparam logic [SW-1:0] STEP_LAST = SW'(FW - 1);

   // The state lives in two memories: the age of each frame, and its referenced bit.
   logic [AGE_BITS-1:0] age_mem [NUM_FRAMES];
   logic                ref_mem [NUM_FRAMES];

   state_type state_ff, state_in;

   logic [7:0]          fiu_ff;
   logic [CW-1:0]       n_ff;
   logic [FW-1:0]       head_ff, head_in;
   logic [FW-1:0]       clr_ff;

   // Modulo unit: restoring division of the head by the frame count.
   logic [FW-1:0]       hsh_ff;
   logic [RW-1:0]       rem_ff, rem_in;
   logic [SW-1:0]       step_ff;

   // Scan sequencer and read pipeline.
   logic [FW-1:0]       f_ff;
   logic [CW-1:0]       iss_ff;
   logic                vld_ff;
   logic [FW-1:0]       raddr_q_ff;
   logic [AGE_BITS-1:0] age_rd_ff;
   logic                ref_rd_ff;
   logic                first_ff;

   logic [FW-1:0]       best_idx_ff, best_idx_in;
   logic [AGE_BITS-1:0] best_age_ff, best_age_in;

   logic                rsp_strobe_ff;
   logic [6:0]          rsp_frame_ff;
   logic [31:0]         rsp_age_ff;

   logic [CW-1:0]       n_cfg;
   logic                accept;
   logic                idx_ok;
   logic [RW-1:0]       r_sh;
   logic [AGE_BITS-1:0] aged;
   logic                take;
   logic [FW-1:0]       f_next;

   logic                age_we, ref_we;
   logic [FW-1:0]       age_wa, ref_wa;
   logic [AGE_BITS-1:0] age_wd;
   logic                ref_wd;

   // A count of zero acts as one, and a count above the table acts as the table size.
   always_comb begin
      if (fiu_ff == 8'd0) begin
         n_cfg = CW'(1);
      end else if (32'(fiu_ff) > NUM_FRAMES) begin
         n_cfg = CW'(NUM_FRAMES);
      end else begin
         n_cfg = CW'(fiu_ff);
      end
   end

   assign accept = start && !busy;
   assign idx_ok = 32'(req_frame_index) < 32'(n_cfg);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == CLR_LAST) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept && req_opcode == OP_VICTIM) state_in = ST_MOD;
         end
         ST_MOD: begin
            if (step_ff == STEP_LAST) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (iss_ff == n_ff - CW'(1)) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and memory write controls.
   always_comb begin
      busy   = (state_ff != ST_IDLE);
      age_we = 1'b0;
      ref_we = 1'b0;
      age_wa = raddr_q_ff;
      ref_wa = raddr_q_ff;
      age_wd = aged;
      ref_wd = 1'b0;
      if (vld_ff) begin
         // Write back the aged frame and clear its referenced bit.
         age_we = 1'b1;
         ref_we = 1'b1;
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               age_we = 1'b1;
               ref_we = 1'b1;
               age_wa = clr_ff;
               ref_wa = clr_ff;
               age_wd = '0;
            end
            ST_IDLE: begin
               age_wa = FW'(req_frame_index);
               ref_wa = FW'(req_frame_index);
               age_wd = '0;
               ref_wd = 1'b1;
               if (accept && idx_ok) begin
                  age_we = (req_opcode == OP_MAP);
                  ref_we = (req_opcode == OP_MAP) || (req_opcode == OP_REFERENCE);
               end
            end
            default: begin
               age_we = 1'b0;
            end
         endcase
      end
   end

   // Datapath: modulo step, aging of the frame just read, and the running minimum.
   always_comb begin
      r_sh   = {rem_ff[RW-2:0], hsh_ff[FW-1]};
      rem_in = (r_sh >= RW'(n_ff)) ? (r_sh - RW'(n_ff)) : r_sh;

      aged = {ref_rd_ff, age_rd_ff[AGE_BITS-1:1]};
      take = first_ff || (aged < best_age_ff);
      best_idx_in = best_idx_ff;
      best_age_in = best_age_ff;
      if (vld_ff && take) begin
         best_idx_in = raddr_q_ff;
         best_age_in = aged;
      end

      f_next  = (CW'(f_ff) + CW'(1) == n_ff) ? '0 : f_ff + FW'(1);
      head_in = (CW'(best_idx_in) + CW'(1) == n_ff) ? '0 : best_idx_in + FW'(1);
   end

   // Memories: one write port and one registered read port each.
   always_ff @(posedge clock) begin
      if (age_we) age_mem[age_wa] <= age_wd;
      if (ref_we) ref_mem[ref_wa] <= ref_wd;
      age_rd_ff <= age_mem[f_ff];
      ref_rd_ff <= ref_mem[f_ff];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         vld_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         head_ff       <= '0;
         fiu_ff        <= FRAMES_RESET;
      end else begin
         state_ff      <= state_in;
         vld_ff        <= (state_ff == ST_SCAN);
         rsp_strobe_ff <= (state_ff == ST_DRAIN);
         if (csr_valid && csr_ready) fiu_ff <= csr_frames_in_use;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + FW'(1);
         if (state_ff == ST_DRAIN) head_ff <= head_in;
      end
   end

   // Payload and sequencing registers; every one is loaded before it is used.
   always_ff @(posedge clock) begin
      raddr_q_ff  <= f_ff;
      best_idx_ff <= best_idx_in;
      best_age_ff <= best_age_in;
      if (vld_ff) first_ff <= 1'b0;
      case (state_ff)
         ST_IDLE: begin
            n_ff    <= n_cfg;
            hsh_ff  <= head_ff;
            rem_ff  <= '0;
            step_ff <= '0;
         end
         ST_MOD: begin
            hsh_ff   <= hsh_ff << 1;
            rem_ff   <= rem_in;
            step_ff  <= step_ff + SW'(1);
            f_ff     <= FW'(rem_in);
            iss_ff   <= '0;
            first_ff <= 1'b1;
         end
         ST_SCAN: begin
            f_ff   <= f_next;
            iss_ff <= iss_ff + CW'(1);
         end
         ST_DRAIN: begin
            rsp_frame_ff <= 7'(best_idx_in);
            rsp_age_ff   <= 32'(best_age_in);
         end
         default: begin
            step_ff <= step_ff;
         end
      endcase
   end

   assign csr_ready        = 1'b1;
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_victim_frame = rsp_frame_ff;
   assign rsp_victim_age   = rsp_age_ff;

   // A result always follows the drain cycle of a scan, never two in a row.
   a_rsp_after_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_DRAIN))
      else $error("result strobe without a finished scan");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   // The scan address stays inside the frames in use.
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (CW'(f_ff) < n_ff))
      else $error("scan address beyond frame count");

   // The partial remainder of the modulo unit stays below the divisor.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOD) |-> (rem_ff < RW'(n_ff)))
      else $error("modulo remainder out of range");

   // Read data is valid exactly in the cycle after a scan read was issued.
   a_read_pipe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |=> vld_ff)
      else $error("scan read lost in the pipeline");

endmodule

FILE: test/aging_page_replacement_test.sv
`timescale 1ns / 100ps

module aging_page_replacement_test;
   import apr_pkg::*;

   // Opcode 3 is not defined by the block; it must be ignored without a result.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam int FRAME_SLOTS  = 128;
   localparam int RANDOM_ITEMS = 700;
   localparam int PHASE_ITEMS  = 100;
   localparam int PHASE_COUNT  = RANDOM_ITEMS / PHASE_ITEMS;
   localparam int DRAIN_CYCLES = 20;

   // The slowest correct gap between accepted beats is a full victim sweep behind a long sender gap,
   // or the clearing pass after reset. The watchdog limit sits several times above either.
   localparam int STALL_LIMIT  = 2000;

   typedef enum logic {
      ROW_ITEM,
      ROW_FRAMES
   } row_kind_type;

   // One row of the directed table: either a frame count write or an item beat. Where typed
   // is set, the victim fields hold the result that is known at a glance, and that result is
   // what the beat is checked against instead of the predicted one.
   typedef struct packed {
      row_kind_type kind;
      logic [7:0]   frames;
      logic [1:0]   opcode;
      logic [6:0]   frame;
      logic         typed;
      logic [6:0]   victim_frame;
      logic [31:0]  victim_age;
   } stim_row_type;

   typedef struct packed {
      logic [6:0]  frame;
      logic [31:0] age;
   } victim_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_opcode;
   logic [6:0]  req_frame_index;
   logic        rsp_strobe;
   logic [6:0]  rsp_victim_frame;
   logic [31:0] rsp_victim_age;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_frames_in_use;

   // Predicted copy of the frame table, scan head and frame count register.
   logic [31:0] table_age [FRAME_SLOTS];
   logic        table_referenced [FRAME_SLOTS];
   int unsigned table_head;
   logic [7:0]  table_frames;

   // Victims still owed by the block, oldest first.
   victim_type  pending_victims [$];

   int          mismatch_count = 0;
   int          beats_taken = 0;
   int          victims_checked = 0;
   int          frame_writes = 0;
   int          stall_cycles = 0;
   bit          steady = 1'b0;

   // The directed part. It opens on a freshly cleared table, where every age is zero, so the
   // first victims simply walk the scan head. Then it touches both ends of the frame index,
   // the unused opcode, indices beyond a small frame count (which must be dropped), a count
   // of zero (acting as one) and a count above the table size (acting as the full table).
   stim_row_type directed_rows [25] = '{
      '{ROW_ITEM,   8'd0,   OP_VICTIM,    7'd0,   1'b1, 7'd0, 32'h0},
      '{ROW_ITEM,   8'd0,   OP_VICTIM,    7'd0,   1'b1, 7'd1, 32'h0},
      '{ROW_ITEM,   8'd0,   OP_REFERENCE, 7'd127, 1'b0, 7'd0, 32'h0},
      '{ROW_ITEM,   8'd0,   OP_MAP,       7'd0,   1'b0, 7'd0, 32'h0},
      '{ROW_ITEM,   8'd0,   OP_UNUSED,    7'd127, 1'b0, 7'd0, 32'h0},
      '{ROW_ITEM,   8'd0,   OP_VICTIM,    7'd0,   1'b1, 7'd2, 32'h0},
      '{ROW_ITEM,   8'd0,   OP_REFERENCE, 7'd3,   1'b0, 7'd0, 32'h0},
      '{ROW_ITEM,   8'd0,   OP_VICTIM,    7'd0,   1'b0, 7'd0, 32'h0},
      '{ROW_FRAMES, 8'd1,   OP_REFERENCE, 7'd0,   1'b0, 7'd0, 32'h0},
      '{ROW_ITEM,   8'd0,   OP_REFERENCE, 7'd0,   1'b0, 7'd0, 32'h0},
      '{ROW_ITEM,   8'd0,   OP_REFERENCE, 7'd1,   1'b0, 7'd0, 32'h0},
      '{ROW_ITEM,   8'd0,   OP_MAP,       7'd127, 1'b0, 7'd0, 32'h0},
      '{ROW_ITEM,   8'd0,   OP_VICTIM,    7'd0,   1'b0, 7'd0, 32'h0},
      '{ROW_FRAMES, 8'd0,   OP_REFERENCE, 7'd0,   1'b0, 7'd0, 32'h0},
      '{ROW_ITEM,   8'd0,   OP_VICTIM,    7'd0,   1'b0, 7'd0, 32'h0},
      '{ROW_FRAMES, 8'd255, OP_REFERENCE, 7'd0,   1'b0, 7'd0, 32'h0},
      '{ROW_ITEM,   8'd0,   OP_MAP,       7'd85,  1'b0, 7'd0, 32'h0},
      '{ROW_ITEM,   8'd0,   OP_REFERENCE, 7'd42,  1'b0, 7'd0, 32'h0},
      '{ROW_ITEM,   8'd0,   OP_VICTIM,    7'd0,   1'b0, 7'd0, 32'h0},
      '{ROW_FRAMES, 8'd2,   OP_REFERENCE, 7'd0,   1'b0, 7'd0, 32'h0},
      '{ROW_ITEM,   8'd0,   OP_VICTIM,    7'd0,   1'b0, 7'd0, 32'h0},
      '{ROW_ITEM,   8'd0,   OP_REFERENCE, 7'd1,   1'b0, 7'd0, 32'h0},
      '{ROW_ITEM,   8'd0,   OP_VICTIM,    7'd0,   1'b0, 7'd0, 32'h0},
      '{ROW_ITEM,   8'd0,   OP_VICTIM,    7'd0,   1'b0, 7'd0, 32'h0},
      '{ROW_FRAMES, 8'd128, OP_REFERENCE, 7'd0,   1'b0, 7'd0, 32'h0}
   };

   aging_page_replacement u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_frame_index   (req_frame_index),
      .rsp_strobe        (rsp_strobe),
      .rsp_victim_frame  (rsp_victim_frame),
      .rsp_victim_age    (rsp_victim_age),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_frames_in_use (csr_frames_in_use)
   );

   // 4 ns clock period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // A count of zero behaves as one frame, and a count above the table as the whole table.
   function automatic int unsigned managed_frames(input logic [7:0] value);
      if (value == 8'd0) begin
         return 1;
      end
      if (value > FRAME_SLOTS) begin
         return FRAME_SLOTS;
      end
      return 32'(value);
   endfunction

   // Applies one accepted beat to the predicted table. A victim request first ages every
   // managed frame (the referenced bit drops into the top of the age), then scans round from
   // the head for the smallest age, the first one seen winning a tie.
   function automatic void age_and_select(input logic [1:0] op, input logic [6:0] idx,
                                          output bit has_victim, output victim_type victim);
      int unsigned n;
      int unsigned pos;
      int unsigned slot;
      int unsigned best;
      logic [31:0] best_age;

      n = managed_frames(table_frames);
      has_victim = 1'b0;
      victim = '0;
      if (op == OP_REFERENCE || op == OP_MAP) begin
         if (idx < n) begin
            table_referenced[idx] = 1'b1;
            if (op == OP_MAP) begin
               table_age[idx] = '0;
            end
         end
      end else if (op == OP_VICTIM) begin
         for (int i = 0; i < n; i++) begin
            table_age[i] = {table_referenced[i], table_age[i][31:1]};
            table_referenced[i] = 1'b0;
         end
         pos = table_head % n;
         best = pos;
         best_age = table_age[pos];
         for (int i = 0; i < n; i++) begin
            slot = (pos + i) % n;
            if (table_age[slot] < best_age) begin
               best = slot;
               best_age = table_age[slot];
            end
         end
         table_head = (best + 1) % n;
         has_victim = 1'b1;
         victim.frame = best[6:0];
         victim.age = best_age;
      end
   endfunction

   // The sender sits out in about 29 beats of a hundred. Most gaps are short, so that they
   // land on every cycle of a sweep, and a few are long enough to cover a whole sweep.
   task automatic sender_gap();
      if (!steady && $urandom_range(99) < 29) begin
         start <= 1'b0;
         if ($urandom_range(7) == 0) begin
            repeat ($urandom_range(1, 160)) @(posedge clock);
         end else begin
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
      end
   endtask

   // Presents one beat and returns at the edge that takes it. Start is left high there, so
   // the caller must either present the next beat or drop start in that same time step.
   task automatic send_beat(input logic [1:0] op, input logic [6:0] idx, input bit typed,
                            input victim_type typed_victim);
      bit         has_victim;
      victim_type victim;
      victim_type expected;

      req_opcode <= op;
      req_frame_index <= idx;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      age_and_select(op, idx, has_victim, victim);
      if (has_victim) begin
         expected = typed ? typed_victim : victim;
         pending_victims.insert(pending_victims.size(), expected);
      end
      beats_taken++;
   endtask

   // The frame count is only changed with the block idle: every owed victim has arrived and
   // busy is low, and the write comes only after a further wait.
   task automatic write_frames(input logic [7:0] value);
      start <= 1'b0;
      @(posedge clock);
      while (pending_victims.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
      if (!steady && $urandom_range(99) < 29) begin
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      csr_valid <= 1'b1;
      csr_frames_in_use <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      table_frames = value;
      frame_writes++;
   endtask

   // Checks every victim beat against the oldest owed victim. The strobe lasts one cycle and
   // cannot be held off, so it is sampled at each rising edge.
   always @(posedge clock) begin
      victim_type owed;

      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_victims.size() == 0) begin
            $error("victim beat with none owed: frame %0d, age 0x%08h",
                   rsp_victim_frame, rsp_victim_age);
            mismatch_count++;
         end else begin
            owed = pending_victims[0];
            pending_victims.delete(0);
            if (rsp_victim_frame !== owed.frame) begin
               $error("victim_frame: expected %0d, actual %0d", owed.frame, rsp_victim_frame);
               mismatch_count++;
            end
            if (rsp_victim_age !== owed.age) begin
               $error("victim_age: expected 0x%08h, actual 0x%08h", owed.age, rsp_victim_age);
               mismatch_count++;
            end
            victims_checked++;
         end
      end
   end

   // Ends the run when nothing at all moves for too long: no beat in, no victim out and no
   // register write.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe === 1'b1 || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no progress for %0d cycles", STALL_LIMIT);
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      logic [7:0]  phase_frames;
      int unsigned n;
      int unsigned pick;
      logic [1:0]  op;
      logic [6:0]  idx;

      reset = 1'b1;
      start = 1'b0;
      req_opcode = OP_REFERENCE;
      req_frame_index = '0;
      csr_valid = 1'b0;
      csr_frames_in_use = '0;

      // The predicted table starts out the way the block leaves reset.
      for (int i = 0; i < FRAME_SLOTS; i++) begin
         table_age[i] = '0;
         table_referenced[i] = 1'b0;
      end
      table_head = 0;
      table_frames = FRAMES_RESET;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed rows. The clearing pass after reset simply shows up as busy on the first one.
      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == ROW_FRAMES) begin
            write_frames(directed_rows[r].frames);
         end else begin
            sender_gap();
            send_beat(directed_rows[r].opcode, directed_rows[r].frame, directed_rows[r].typed,
                      {directed_rows[r].victim_frame, directed_rows[r].victim_age});
         end
      end

      // Random phases, each under its own frame count. One phase runs with no idling at all.
      // Indices mostly fall inside the managed frames, where they matter, with a tenth drawn
      // over the whole field so that small counts also see dropped beats.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: phase_frames = 8'd3;
            1: phase_frames = 8'd128;
            2: phase_frames = 8'd1;
            3: phase_frames = 8'd17;
            4: phase_frames = 8'd255;
            5: phase_frames = 8'd64;
            default: phase_frames = 8'($urandom_range(255));
         endcase
         write_frames(phase_frames);
         steady = (phase == 3);
         n = managed_frames(phase_frames);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
               op = OP_REFERENCE;
            end else if (pick < 60) begin
               op = OP_MAP;
            end else if (pick < 92) begin
               op = OP_VICTIM;
            end else begin
               op = OP_UNUSED;
            end
            if ($urandom_range(9) == 0) begin
               idx = 7'($urandom_range(127));
            end else begin
               idx = 7'($urandom_range(n - 1));
            end
            sender_gap();
            send_beat(op, idx, 1'b0, '0);
         end
      end
      steady = 1'b0;

      // Wait for every owed victim, then a little longer to catch any stray strobe.
      start <= 1'b0;
      @(posedge clock);
      while (pending_victims.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d beats and %0d checked victims over %0d frame count writes,",
               beats_taken, victims_checked, frame_writes);
      $display("with counts from zero through 255 and out-of-range and unused-opcode beats.");
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/apr_pkg.sv
hw/rtl/aging_page_replacement.sv
test/aging_page_replacement_test.sv
